// ----- src/tbat_pkg.sv -----
// tbat_pkg: shared types, constants and helper functions for the track box acceptance core
// used by every module under src; no dependencies of its own
package tbat_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_AXES        = 3;
    localparam int NUM_FACES       = 6;
    localparam int IN_W            = 6 * FIELD_W;
    localparam int OUT_W           = 8;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOT_Z = 3'd0,
        REG_BOT_X = 3'd1,
        REG_BOT_Y = 3'd2,
        REG_BOX_X = 3'd3,
        REG_BOX_Y = 3'd4,
        REG_BOX_Z = 3'd5
    } cfg_idx_t;

    // raw 16-bit carriers of every configured level, index 0 x, 1 y, 2 z
    typedef struct packed {
        logic [FIELD_W-1:0]            bot_z;
        logic [1:0][FIELD_W-1:0]       bwin_lo;
        logic [1:0][FIELD_W-1:0]       bwin_hi;
        logic [NUM_AXES-1:0][FIELD_W-1:0] box_lo;
        logic [NUM_AXES-1:0][FIELD_W-1:0] box_hi;
    } cfg_t;

    // signed width that holds a decoded coordinate
    function automatic int val_width(input int cw);
        return (cw > FIELD_W) ? FIELD_W + 1 : cw;
    endfunction

    // carrier bits that take part in a coordinate
    function automatic int raw_width(input int cw);
        return (cw < FIELD_W) ? cw : FIELD_W;
    endfunction

    // face order: z min, z max, x min, x max, y min, y max
    function automatic int face_axis(input int f);
        int a;
        case (f)
            0, 1:    a = 2;
            2, 3:    a = 0;
            default: a = 1;
        endcase
        return a;
    endfunction

    // the two in-face axes of a plane normal to axis a, in ascending order
    function automatic int other_axis(input int a, input int j);
        int k;
        if (j == 0)
            k = (a == 0) ? 1 : 0;
        else
            k = (a == 2) ? 1 : 2;
        return k;
    endfunction

endpackage

// ----- src/tbat_cfg_regs.sv -----
// tbat_cfg_regs: write-only configuration register file
// depends on tbat_pkg
module tbat_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tbat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbat_pkg::CFG_W-1:0]     cfg_wdata,
    output tbat_pkg::cfg_t                 cfg
);
    import tbat_pkg::*;

    logic [FIELD_W-1:0]          bot_z_reg;
    logic [1:0][CFG_W-1:0]       win_reg;
    logic [NUM_AXES-1:0][CFG_W-1:0] box_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bot_z_reg <= '0;
            win_reg   <= '0;
            box_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_BOT_Z: bot_z_reg  <= cfg_wdata[FIELD_W-1:0];
                REG_BOT_X: win_reg[0] <= cfg_wdata;
                REG_BOT_Y: win_reg[1] <= cfg_wdata;
                REG_BOX_X: box_reg[0] <= cfg_wdata;
                REG_BOX_Y: box_reg[1] <= cfg_wdata;
                REG_BOX_Z: box_reg[2] <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // split packed windows into their halves
    always_comb
    begin
        cfg.bot_z = bot_z_reg;
        for (int j = 0; j < 2; j++)
        begin
            cfg.bwin_lo[j] = win_reg[j][FIELD_W-1:0];
            cfg.bwin_hi[j] = win_reg[j][CFG_W-1:FIELD_W];
        end
        for (int k = 0; k < NUM_AXES; k++)
        begin
            cfg.box_lo[k] = box_reg[k][FIELD_W-1:0];
            cfg.box_hi[k] = box_reg[k][CFG_W-1:FIELD_W];
        end
    end

endmodule

// ----- src/tbat_diff_stage.sv -----
// tbat_diff_stage: first pipeline stage, decodes coordinates and forms offset differences
// depends on tbat_pkg
module tbat_diff_stage #(
    parameter int COORD_WIDTH = tbat_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [tbat_pkg::NUM_AXES-1:0][tbat_pkg::FIELD_W-1:0] pos,
    input  logic [tbat_pkg::NUM_AXES-1:0][tbat_pkg::FIELD_W-1:0] dir,
    input  tbat_pkg::cfg_t                         cfg,
    output logic                                   valid_reg,
    output logic signed [tbat_pkg::val_width(COORD_WIDTH)-1:0] m_reg [tbat_pkg::NUM_AXES],
    output logic [tbat_pkg::NUM_AXES-1:0]          nz_reg,
    output logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbot_reg,
    output logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbw_reg [2][2],
    output logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dfl_reg [tbat_pkg::NUM_FACES],
    output logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbx_reg [tbat_pkg::NUM_AXES][2]
);
    import tbat_pkg::*;

    localparam int LW = raw_width(COORD_WIDTH);
    localparam int VW = val_width(COORD_WIDTH);
    localparam int DW = VW + 1;

    // low carrier bits, sign taken from the top bit unless zero-extended
    function automatic logic signed [VW-1:0] coord(input logic [FIELD_W-1:0] raw);
        return $signed(VW'(raw[LW-1:0]));
    endfunction

    logic signed [VW-1:0] p_c  [NUM_AXES];
    logic signed [VW-1:0] m_c  [NUM_AXES];
    logic signed [VW-1:0] lo_c [NUM_AXES];
    logic signed [VW-1:0] hi_c [NUM_AXES];
    logic signed [VW-1:0] bz_c;
    logic signed [VW-1:0] bwl_c [2];
    logic signed [VW-1:0] bwh_c [2];

    // decode all coordinates
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            p_c[k]  = coord(pos[k]);
            m_c[k]  = coord(dir[k]);
            lo_c[k] = coord(cfg.box_lo[k]);
            hi_c[k] = coord(cfg.box_hi[k]);
        end
        bz_c = coord(cfg.bot_z);
        for (int j = 0; j < 2; j++)
        begin
            bwl_c[j] = coord(cfg.bwin_lo[j]);
            bwh_c[j] = coord(cfg.bwin_hi[j]);
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // direction, zero flags, bottom plane offsets and box bound offsets
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                m_reg[k]     <= m_c[k];
                nz_reg[k]    <= (m_c[k] != '0);
                dbx_reg[k][0] <= DW'(p_c[k]) - DW'(lo_c[k]);
                dbx_reg[k][1] <= DW'(p_c[k]) - DW'(hi_c[k]);
            end
            dbot_reg <= DW'(bz_c) - DW'(p_c[2]);
            for (int j = 0; j < 2; j++)
            begin
                dbw_reg[j][0] <= DW'(p_c[j]) - DW'(bwl_c[j]);
                dbw_reg[j][1] <= DW'(p_c[j]) - DW'(bwh_c[j]);
            end
        end
    end

    // level minus start point for each box face
    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        localparam int A = face_axis(f);
        always_ff @(posedge clk)
        begin
            if (en)
                dfl_reg[f] <= DW'((f % 2 == 1) ? hi_c[A] : lo_c[A]) - DW'(p_c[A]);
        end
    end

endmodule

// ----- src/tbat_prod_stage.sv -----
// tbat_prod_stage: second pipeline stage, one row of registered cross products
// depends on tbat_pkg
module tbat_prod_stage #(
    parameter int COORD_WIDTH = tbat_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [tbat_pkg::val_width(COORD_WIDTH)-1:0] m_in [tbat_pkg::NUM_AXES],
    input  logic [tbat_pkg::NUM_AXES-1:0]          nz_in,
    input  logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbot_in,
    input  logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbw_in [2][2],
    input  logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dfl_in [tbat_pkg::NUM_FACES],
    input  logic signed [tbat_pkg::val_width(COORD_WIDTH):0] dbx_in [tbat_pkg::NUM_AXES][2],
    output logic                                   valid_reg,
    output logic [tbat_pkg::NUM_AXES-1:0]          msign_reg,
    output logic [tbat_pkg::NUM_AXES-1:0]          nz_reg,
    output logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] bl_reg [2],
    output logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] bx_reg [2][2],
    output logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] fl_reg [tbat_pkg::NUM_FACES][2],
    output logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] fx_reg [tbat_pkg::NUM_AXES][2][2]
);
    import tbat_pkg::*;

    localparam int VW = val_width(COORD_WIDTH);
    localparam int PW = 2 * VW + 1;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // direction signs and zero flags travel alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_AXES; k++)
                msign_reg[k] <= m_in[k][VW-1];
            nz_reg <= nz_in;
        end
    end

    // bottom plane products
    for (genvar j = 0; j < 2; j++)
    begin : g_bot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bl_reg[j]    <= PW'(dbot_in * m_in[j]);
                bx_reg[j][0] <= PW'(dbw_in[j][0] * m_in[2]);
                bx_reg[j][1] <= PW'(dbw_in[j][1] * m_in[2]);
            end
        end
    end

    // level offset times in-face direction, per face
    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_fl
        for (genvar j = 0; j < 2; j++)
        begin : g_j
            localparam int K = other_axis(face_axis(f), j);
            always_ff @(posedge clk)
            begin
                if (en)
                    fl_reg[f][j] <= PW'(dfl_in[f] * m_in[K]);
            end
        end
    end

    // bound offset times normal direction, shared by both faces of an axis
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_fx
        for (genvar j = 0; j < 2; j++)
        begin : g_j
            localparam int K = other_axis(a, j);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    fx_reg[a][j][0] <= PW'(dbx_in[K][0] * m_in[a]);
                    fx_reg[a][j][1] <= PW'(dbx_in[K][1] * m_in[a]);
                end
            end
        end
    end

endmodule

// ----- src/tbat_decide_stage.sv -----
// tbat_decide_stage: third and fourth pipeline stages, sign tests and final accept bit
// depends on tbat_pkg
module tbat_decide_stage #(
    parameter int COORD_WIDTH = tbat_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [tbat_pkg::NUM_AXES-1:0]          msign_in,
    input  logic [tbat_pkg::NUM_AXES-1:0]          nz_in,
    input  logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] bl_in [2],
    input  logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] bx_in [2][2],
    input  logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] fl_in [tbat_pkg::NUM_FACES][2],
    input  logic signed [2*tbat_pkg::val_width(COORD_WIDTH):0] fx_in [tbat_pkg::NUM_AXES][2][2],
    output logic                                   mid_valid_reg,
    output logic                                   valid_reg,
    output logic                                   acc_reg
);
    import tbat_pkg::*;

    localparam int VW = val_width(COORD_WIDTH);
    localparam int PW = 2 * VW + 1;
    localparam int SW = PW + 1;

    // crossing beyond the bound, sense flipped by the normal's sign
    function automatic logic side_pos(input logic signed [SW-1:0] n, input logic ms);
        return (n != '0) && (n[SW-1] == ms);
    endfunction

    function automatic logic side_neg(input logic signed [SW-1:0] n, input logic ms);
        return (n != '0) && (n[SW-1] != ms);
    endfunction

    logic signed [SW-1:0] nb_lo [2];
    logic signed [SW-1:0] nb_hi [2];
    logic [NUM_FACES-1:0] hit_next;
    logic [NUM_FACES-1:0] hit_reg;
    logic                 bot_ok_next;
    logic                 bot_ok_reg;

    // bottom window sums
    for (genvar j = 0; j < 2; j++)
    begin : g_bot
        assign nb_lo[j] = SW'(bx_in[j][0]) + SW'(bl_in[j]);
        assign nb_hi[j] = SW'(bx_in[j][1]) + SW'(bl_in[j]);
    end

    // inclusive window on the bottom plane
    always_comb
    begin
        bot_ok_next = nz_in[2];
        for (int j = 0; j < 2; j++)
        begin
            if (side_neg(nb_lo[j], msign_in[2]) || side_pos(nb_hi[j], msign_in[2]))
                bot_ok_next = 1'b0;
        end
    end

    // strict in-face test on each box face
    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        localparam int A = face_axis(f);
        logic signed [SW-1:0] n_lo [2];
        logic signed [SW-1:0] n_hi [2];
        for (genvar j = 0; j < 2; j++)
        begin : g_j
            assign n_lo[j] = SW'(fx_in[A][j][0]) + SW'(fl_in[f][j]);
            assign n_hi[j] = SW'(fx_in[A][j][1]) + SW'(fl_in[f][j]);
        end
        assign hit_next[f] = nz_in[A]
                           && side_pos(n_lo[0], msign_in[A]) && side_neg(n_hi[0], msign_in[A])
                           && side_pos(n_lo[1], msign_in[A]) && side_neg(n_hi[1], msign_in[A]);
    end

    // valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= in_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    // test results, then the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bot_ok_reg <= bot_ok_next;
            hit_reg    <= hit_next;
            acc_reg    <= bot_ok_reg && (hit_reg != '0);
        end
    end

`ifndef SYNTH
    // a face whose normal component is zero never reports a hit
    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_chk
        localparam int A = face_axis(f);
        a_zero_dir_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
            en && in_valid && !nz_in[A] |=> !hit_reg[f])
            else $error("face hit with zero normal direction");
    end

    // a track outside the bottom window is never accepted
    a_bottom_gate: assert property (@(posedge clk) disable iff (!rst_n)
        en && mid_valid_reg && !bot_ok_reg |=> !acc_reg)
        else $error("accept without bottom window pass");
`endif

endmodule

// ----- src/track_box_acceptance_test_core.sv -----
// track_box_acceptance_test_core: top level of the track box acceptance pipeline
// depends on tbat_pkg, tbat_cfg_regs, tbat_diff_stage, tbat_prod_stage, tbat_decide_stage
//
//  channel   | direction | beat contents
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | one track: start point and direction
//  m_axis    | out       | one accept bit per track
//  cfg       | in        | register write, index and data, no read-back
//
// one track per cycle sustained while the output is not stalled; a result leaves once its beat
// has passed the four register stages: differences, the multiplier row, sign tests, output
// reset clears all valid bits and zeroes the configuration registers, data stages unreset
// when an output beat waits the whole pipeline holds, s_axis_tready falls with it
module track_box_acceptance_test_core #(
    parameter int COORD_WIDTH = tbat_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, 16 bits each from bit 0 up
    input  logic [tbat_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // accepted at bit 0, bits 7:1 zero
    output logic [tbat_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [tbat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbat_pkg::CFG_W-1:0]     cfg_wdata
);
    import tbat_pkg::*;

    localparam int VW = val_width(COORD_WIDTH);
    localparam int DW = VW + 1;
    localparam int PW = 2 * VW + 1;

    cfg_t                       cfg;
    logic                       en;
    logic [NUM_AXES-1:0][FIELD_W-1:0] pos;
    logic [NUM_AXES-1:0][FIELD_W-1:0] dir;

    logic                       v1;
    logic signed [VW-1:0]       d_m    [NUM_AXES];
    logic [NUM_AXES-1:0]        d_nz;
    logic signed [DW-1:0]       d_dbot;
    logic signed [DW-1:0]       d_dbw  [2][2];
    logic signed [DW-1:0]       d_dfl  [NUM_FACES];
    logic signed [DW-1:0]       d_dbx  [NUM_AXES][2];

    logic                       v2;
    logic [NUM_AXES-1:0]        p_msign;
    logic [NUM_AXES-1:0]        p_nz;
    logic signed [PW-1:0]       p_bl   [2];
    logic signed [PW-1:0]       p_bx   [2][2];
    logic signed [PW-1:0]       p_fl   [NUM_FACES][2];
    logic signed [PW-1:0]       p_fx   [NUM_AXES][2][2];

    logic                       v3;
    logic                       v4;
    logic                       acc;

    // global advance: move on unless a result waits
    assign en            = !v4 || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v4;
    assign m_axis_tdata  = OUT_W'(acc);

    // unpack the input beat
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            pos[k] = s_axis_tdata[k*FIELD_W +: FIELD_W];
            dir[k] = s_axis_tdata[(NUM_AXES+k)*FIELD_W +: FIELD_W];
        end
    end

    tbat_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbat_diff_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .pos       (pos),
        .dir       (dir),
        .cfg       (cfg),
        .valid_reg (v1),
        .m_reg     (d_m),
        .nz_reg    (d_nz),
        .dbot_reg  (d_dbot),
        .dbw_reg   (d_dbw),
        .dfl_reg   (d_dfl),
        .dbx_reg   (d_dbx)
    );

    tbat_prod_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .m_in      (d_m),
        .nz_in     (d_nz),
        .dbot_in   (d_dbot),
        .dbw_in    (d_dbw),
        .dfl_in    (d_dfl),
        .dbx_in    (d_dbx),
        .valid_reg (v2),
        .msign_reg (p_msign),
        .nz_reg    (p_nz),
        .bl_reg    (p_bl),
        .bx_reg    (p_bx),
        .fl_reg    (p_fl),
        .fx_reg    (p_fx)
    );

    tbat_decide_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (v2),
        .msign_in      (p_msign),
        .nz_in         (p_nz),
        .bl_in         (p_bl),
        .bx_in         (p_bx),
        .fl_in         (p_fl),
        .fx_in         (p_fx),
        .mid_valid_reg (v3),
        .valid_reg     (v4),
        .acc_reg       (acc)
    );

`ifndef SYNTH
    // a stall freezes every valid bit of the pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({v1, v2, v3, v4}))
        else $error("pipeline moved during a stall");

    // an empty pipeline with no new beat shows no result
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready) && !v1 && !v2 && !v3 && !v4 |=> !m_axis_tvalid)
        else $error("result beat without a track");

    // a waiting result keeps its accept bit until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        v4 && !m_axis_tready |=> v4 && $stable(acc))
        else $error("waiting result changed");
`endif

endmodule
